@@ rtl/fpp_pkg.sv @@
// shared types, constants and the piece lookup of the position parser
`default_nettype none

package fpp_pkg;

	localparam int CLOCK_BITS_DEF = 16;
	localparam int QUEUE_AW = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_W = 8'h77;

	typedef struct packed {
		logic       last;
		logic       ws;
		logic       is_digit;
		logic [3:0] digit;
		logic [3:0] piece;
		logic       slash;
		logic       is_w;
		logic       is_dash;
		logic [3:0] castle_mask;
		logic [2:0] pfile;
		logic [2:0] prank;
	} token_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  square;
		logic [3:0]  piece;
		logic        white_to_move;
		logic [3:0]  castling;
		logic [6:0]  passant_square;
		logic [15:0] halfmove_count;
		logic [15:0] fullmove_count;
	} result_t;

	function automatic logic [3:0] piece_code(input logic [7:0] c);
		case (c)
			"P": piece_code = 4'd1;
			"N": piece_code = 4'd2;
			"B": piece_code = 4'd3;
			"R": piece_code = 4'd4;
			"Q": piece_code = 4'd5;
			"K": piece_code = 4'd6;
			"p": piece_code = 4'd9;
			"n": piece_code = 4'd10;
			"b": piece_code = 4'd11;
			"r": piece_code = 4'd12;
			"q": piece_code = 4'd13;
			"k": piece_code = 4'd14;
			default: piece_code = 4'd0;
		endcase
	endfunction

	function automatic logic [3:0] castle_code(input logic [7:0] c);
		case (c)
			"K": castle_code = 4'b0001;
			"Q": castle_code = 4'b0010;
			"k": castle_code = 4'b0100;
			"q": castle_code = 4'b1000;
			default: castle_code = 4'b0000;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ rtl/fen_position_parser_top.sv @@
// top level of the chess position text parser
// Input: one ASCII character per transaction on s_axis_tdata, s_axis_tlast on the
// final character of a position. Output: one transaction per on-board piece letter of the
// placement field (m_axis_tuser 0, square and piece) and one summary transaction
// after the final character (m_axis_tuser 1: side, castling, en passant, clocks).
// Characters that write nothing produce no output transaction.
// A result is registered: the token of its character is written into the queue,
// then read, applied and registered in the output register; an output stall holds it in the queue.
// Throughput: one character per cycle sustained while m_axis_tready stays high, set by
// the state update of the back end; the four-entry token queue absorbs short stalls.
// When m_axis_tready is low the output register holds, the queue fills, and
// s_axis_tready drops once four tokens are waiting.
// Reset (arst_n low) empties the queue, drops any pending result and returns the
// parser to the placement field at rank 7, file 0; the state also returns there
// after every summary.
`default_nettype none

module fen_position_parser_top #(
	parameter int CLOCK_BITS = fpp_pkg::CLOCK_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // char_code
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // square, piece, white_to_move, castling,
	                                         // passant_square, halfmove_count, fullmove_count
	output logic             m_axis_tuser    // kind
);
	import fpp_pkg::*;

	logic    push;
	logic    pop;
	logic    full;
	logic    empty;
	token_t  push_token;
	token_t  head;
	result_t result;

	fpp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.full          (full),
		.push          (push),
		.token         (push_token)
	);

	fpp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	fpp_back #(
		.CLOCK_BITS (CLOCK_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.tok     (head),
		.pop     (pop),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.result  (result)
	);

	assign m_axis_tuser = result.kind;
	assign m_axis_tdata = {2'b00, result.fullmove_count, result.halfmove_count,
		result.passant_square, result.castling, result.white_to_move,
		result.piece, result.square};

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_WRITE) |-> m_axis_tdata[9:6] != 4'd0)
		else $error("square write without a piece");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_WRITE) |-> m_axis_tdata[55:10] == '0)
		else $error("square write carries summary fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY) |-> m_axis_tdata[9:0] == '0)
		else $error("summary carries square fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !s_axis_tready)
		else $error("input taken while token queue full");
`endif

endmodule

`default_nettype wire

@@ rtl/fpp_front.sv @@
// front end: accepts characters and classifies them into tokens
`default_nettype none

module fpp_front (
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [7:0]      s_axis_tdata,
	input  wire logic            s_axis_tlast,
	input  wire logic            full,
	output logic                 push,
	output fpp_pkg::token_t      token
);
	import fpp_pkg::*;

	logic [7:0] c;
	logic [7:0] fdiff;
	logic [7:0] rdiff;

	assign c = s_axis_tdata;
	assign fdiff = c - CH_LOW_A;
	assign rdiff = c - CH_ONE;

	assign s_axis_tready = !full;
	assign push = s_axis_tvalid && !full;

	always_comb begin
		token.last = s_axis_tlast;
		token.ws = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
		token.is_digit = c inside {[CH_ZERO:CH_NINE]};
		token.digit = c[3:0];
		token.piece = piece_code(c);
		token.slash = (c == CH_SLASH);
		token.is_w = (c == CH_LOW_W);
		token.is_dash = (c == CH_DASH);
		token.castle_mask = castle_code(c);
		token.pfile = fdiff[2:0];
		token.prank = rdiff[2:0];
	end

endmodule

`default_nettype wire

@@ rtl/fpp_queue.sv @@
// short token queue between the front end and the back end
`default_nettype none

module fpp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire fpp_pkg::token_t  push_token,
	input  wire logic             pop,
	output fpp_pkg::token_t       head,
	output logic                  full,
	output logic                  empty
);
	import fpp_pkg::*;

	token_t               slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/fpp_back.sv @@
// back end: field tracking, square writes and the position summary
`default_nettype none

module fpp_back #(
	parameter int CLOCK_BITS = fpp_pkg::CLOCK_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             empty,
	input  wire fpp_pkg::token_t  tok,
	output logic                  pop,
	output logic                  m_valid,
	input  wire logic             m_ready,
	output fpp_pkg::result_t      result
);
	import fpp_pkg::*;

	localparam logic [2:0] FLD_PLACE = 3'd0;
	localparam logic [2:0] FLD_SIDE = 3'd1;
	localparam logic [2:0] FLD_CASTLE = 3'd2;
	localparam logic [2:0] FLD_PASSANT = 3'd3;
	localparam logic [2:0] FLD_HALF = 3'd4;
	localparam logic [2:0] FLD_FULL = 3'd5;
	localparam logic [2:0] FLD_EXTRA = 3'd6;

	logic [2:0]            field_q, field_d;
	logic                  in_sep_q, in_sep_d;
	logic                  started_q, started_d;
	logic [2:0]            rank_q, rank_d;
	logic                  rank_gone_q, rank_gone_d;
	logic [3:0]            file_q, file_d;
	logic                  side_flag_q, side_flag_d;
	logic [1:0]            side_len_q, side_len_d;
	logic [3:0]            castle_q, castle_d;
	logic [2:0]            pfile_q, pfile_d;
	logic [2:0]            prank_q, prank_d;
	logic                  pvalid_q, pvalid_d;
	logic [1:0]            pcount_q, pcount_d;
	logic [CLOCK_BITS-1:0] half_q, half_d;
	logic [CLOCK_BITS-1:0] full_q, full_d;
	logic                  dstop_q, dstop_d;

	logic                  emit;
	logic [5:0]            wsq;
	logic [4:0]            file_sum;
	logic [CLOCK_BITS-1:0] acc_sel;
	logic [CLOCK_BITS+3:0] acc_next;
	logic [CLOCK_BITS-1:0] acc_sat;
	logic [CLOCK_BITS+15:0] half_ext;
	logic [CLOCK_BITS+15:0] full_ext;
	logic [15:0]           half_out;
	logic [15:0]           full_out;

	logic                  out_valid_q;
	result_t               out_q;

	assign pop = !empty && (!out_valid_q || m_ready);
	assign m_valid = out_valid_q;
	assign result = out_q;

	// acc * 10 + digit with saturation
	assign acc_sel = (field_d == FLD_HALF) ? half_q : full_q;
	assign acc_next = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
		+ (CLOCK_BITS+4)'(tok.digit);
	assign acc_sat = (acc_next[CLOCK_BITS+3:CLOCK_BITS] != '0) ? '1 : acc_next[CLOCK_BITS-1:0];
	assign file_sum = {1'b0, file_q} + {1'b0, tok.digit};

	always_comb begin
		field_d = field_q;
		in_sep_d = in_sep_q;
		started_d = started_q;
		rank_d = rank_q;
		rank_gone_d = rank_gone_q;
		file_d = file_q;
		side_flag_d = side_flag_q;
		side_len_d = side_len_q;
		castle_d = castle_q;
		pfile_d = pfile_q;
		prank_d = prank_q;
		pvalid_d = pvalid_q;
		pcount_d = pcount_q;
		half_d = half_q;
		full_d = full_q;
		dstop_d = dstop_q;
		emit = 1'b0;
		wsq = {rank_q, file_q[2:0]};
		if (tok.ws) begin
			if (started_q) begin
				in_sep_d = 1'b1;
			end
		end else begin
			if (in_sep_q) begin
				if (field_q < FLD_EXTRA) begin
					field_d = field_q + 3'd1;
				end
				in_sep_d = 1'b0;
				pcount_d = 2'd0;
				dstop_d = 1'b0;
			end
			started_d = 1'b1;
			case (field_d)
				FLD_PLACE: begin
					if (tok.piece != 4'd0) begin
						emit = !rank_gone_q && !file_q[3];
						file_d = file_q[3] ? file_q : file_q + 4'd1;
					end else if (tok.is_digit) begin
						file_d = (file_sum > 5'd8) ? 4'd8 : file_sum[3:0];
					end else if (tok.slash) begin
						if (rank_q == 3'd0) begin
							rank_gone_d = 1'b1;
						end else begin
							rank_d = rank_q - 3'd1;
						end
						file_d = 4'd0;
					end else begin
						file_d = file_q[3] ? file_q : file_q + 4'd1;
					end
				end
				FLD_SIDE: begin
					if (side_len_q == 2'd0) begin
						side_flag_d = tok.is_w;
					end
					if (side_len_q != 2'd3) begin
						side_len_d = side_len_q + 2'd1;
					end
				end
				FLD_CASTLE: begin
					castle_d = castle_q | tok.castle_mask;
				end
				FLD_PASSANT: begin
					if (pcount_d == 2'd0) begin
						pvalid_d = !tok.is_dash;
						if (!tok.is_dash) begin
							pfile_d = tok.pfile;
						end
					end else if (pcount_d == 2'd1) begin
						prank_d = tok.prank;
					end
					if (pcount_d < 2'd2) begin
						pcount_d = pcount_d + 2'd1;
					end
				end
				FLD_HALF, FLD_FULL: begin
					if (!dstop_d) begin
						if (tok.is_digit) begin
							if (field_d == FLD_HALF) begin
								half_d = acc_sat;
							end else begin
								full_d = acc_sat;
							end
						end else begin
							dstop_d = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign half_ext = (CLOCK_BITS+16)'(half_d);
	assign full_ext = (CLOCK_BITS+16)'(full_d);
	assign half_out = (half_ext > (CLOCK_BITS+16)'(17'h0FFFF)) ? 16'hFFFF : half_ext[15:0];
	assign full_out = (full_ext > (CLOCK_BITS+16)'(17'h0FFFF)) ? 16'hFFFF : full_ext[15:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			if (tok.last) begin
				out_q.kind <= KIND_SUMMARY;
				out_q.square <= '0;
				out_q.piece <= '0;
				out_q.white_to_move <= side_flag_d && (side_len_d == 2'd1);
				out_q.castling <= castle_d;
				out_q.passant_square <= pvalid_d ? {1'b0, prank_d, pfile_d} : 7'h7F;
				out_q.halfmove_count <= half_out;
				out_q.fullmove_count <= full_out;
			end else begin
				out_q.kind <= KIND_WRITE;
				out_q.square <= wsq;
				out_q.piece <= tok.piece;
				out_q.white_to_move <= 1'b0;
				out_q.castling <= '0;
				out_q.passant_square <= '0;
				out_q.halfmove_count <= '0;
				out_q.fullmove_count <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			field_q <= FLD_PLACE;
			in_sep_q <= 1'b0;
			started_q <= 1'b0;
			rank_q <= 3'd7;
			rank_gone_q <= 1'b0;
			file_q <= 4'd0;
			side_flag_q <= 1'b0;
			side_len_q <= 2'd0;
			castle_q <= 4'd0;
			pfile_q <= 3'd0;
			prank_q <= 3'd0;
			pvalid_q <= 1'b0;
			pcount_q <= 2'd0;
			half_q <= '0;
			full_q <= '0;
			dstop_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= tok.last || emit;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (tok.last) begin
					// end of text: back to the start of a new position
					field_q <= FLD_PLACE;
					in_sep_q <= 1'b0;
					started_q <= 1'b0;
					rank_q <= 3'd7;
					rank_gone_q <= 1'b0;
					file_q <= 4'd0;
					side_flag_q <= 1'b0;
					side_len_q <= 2'd0;
					castle_q <= 4'd0;
					pfile_q <= 3'd0;
					prank_q <= 3'd0;
					pvalid_q <= 1'b0;
					pcount_q <= 2'd0;
					half_q <= '0;
					full_q <= '0;
					dstop_q <= 1'b0;
				end else begin
					field_q <= field_d;
					in_sep_q <= in_sep_d;
					started_q <= started_d;
					rank_q <= rank_d;
					rank_gone_q <= rank_gone_d;
					file_q <= file_d;
					side_flag_q <= side_flag_d;
					side_len_q <= side_len_d;
					castle_q <= castle_d;
					pfile_q <= pfile_d;
					prank_q <= prank_d;
					pvalid_q <= pvalid_d;
					pcount_q <= pcount_d;
					half_q <= half_d;
					full_q <= full_d;
					dstop_q <= dstop_d;
				end
			end
		end
	end

endmodule

`default_nettype wire
